@@ sv/spmd_pkg.sv @@
// package: payload types and constants for the segment pair minimum distance block
`default_nettype none
package spmd_pkg;

  typedef struct packed {
    logic [59:0] seg_a_start;
    logic [59:0] seg_a_end;
    logic [59:0] seg_b_start;
    logic [59:0] seg_b_end;
    logic        first_pair;
    logic        last_pair;
  } spmd_in_t;

  typedef struct packed {
    logic [20:0] min_distance;
    logic [59:0] closest_on_a;
    logic [59:0] closest_on_b;
  } spmd_out_t;

  localparam int COORD_W   = 20;
  localparam int DIFF_W    = 21;
  localparam int ACC_W     = 46;
  localparam int GRAM_W    = 36;
  localparam int MUL_W     = 35;
  localparam int COEF_FRAC = 16;
  localparam int DIST_W    = 21;

  localparam logic signed [GRAM_W-1:0] EPS_Q10  = GRAM_W'(10);
  localparam logic [COEF_FRAC:0]       COEF_ONE = {1'b1, {COEF_FRAC{1'b0}}};
  localparam logic [DIST_W-1:0]        DIST_INIT = {DIST_W{1'b1}};
  localparam logic [ACC_W-1:0]         SQRT_BIT0 = ACC_W'(1) << 44;

endpackage
`default_nettype wire

@@ sv/segment_pair_min_distance.sv @@
// top level: closest points of two 3d segments and running minimum distance of a run
// in_ready drops on acceptance and returns after the update, so a new item waits until then:
// 15 dot product steps, 6 matrix products, a clamp check per coefficient (up to 2 x 16 divider
// steps), 6 point steps, 3 distance steps, 23 square root steps and 1 update, on one 35x35 mult
// out_valid rises with in_ready after a last pair; a waiting result holds the update of the next last pair
// synchronous active-low reset clears control and the running minimum (distance all ones)
`default_nettype none
module segment_pair_min_distance import spmd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire spmd_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output spmd_out_t      out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DOT, S_MAT, S_COEF, S_DIV, S_PNT, S_DSQ, S_SQRT, S_UPD
  } state_t;

  state_t                     state_r;
  logic [4:0]                 cnt_r;
  logic [2:0]                 dp_r;
  logic                       sel_r;
  logic                       first_r, last_r;
  logic signed [COORD_W-1:0]  a0_r [3];
  logic signed [COORD_W-1:0]  b0_r [3];
  logic signed [DIFF_W-1:0]   u_r [3];
  logic signed [DIFF_W-1:0]   v_r [3];
  logic signed [DIFF_W-1:0]   h_r [3];
  logic signed [DIFF_W-1:0]   w_r [3];
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [GRAM_W-1:0]   g_r [5];
  logic [63:0]                prod_r, det_r, pma_r, qma_r, pmb_r, qmb_r;
  logic [63:0]                rem_r;
  logic [COEF_FRAC-1:0]       q_r;
  logic [COEF_FRAC:0]         alpha_r, beta_r;
  logic signed [COORD_W-1:0]  pa_r [3];
  logic signed [COORD_W-1:0]  pb_r [3];
  logic [ACC_W-1:0]           sq_x_r, sq_res_r, sq_bit_r;
  logic [DIST_W-1:0]          best_dist_r;
  logic [59:0]                best_a_r, best_b_r;
  logic                       out_valid_r;
  spmd_out_t                  out_r;

  // input unpacking
  logic signed [COORD_W-1:0] ld_a0 [3];
  logic signed [COORD_W-1:0] ld_a1 [3];
  logic signed [COORD_W-1:0] ld_b0 [3];
  logic signed [COORD_W-1:0] ld_b1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ld_a0[i] = signed'(in_data.seg_a_start[COORD_W*i +: COORD_W]);
      ld_a1[i] = signed'(in_data.seg_a_end[COORD_W*i +: COORD_W]);
      ld_b0[i] = signed'(in_data.seg_b_start[COORD_W*i +: COORD_W]);
      ld_b1[i] = signed'(in_data.seg_b_end[COORD_W*i +: COORD_W]);
    end
  end

  // gram terms
  logic signed [GRAM_W-1:0] muu_s, mvv_s, nuv, nr0, nr1;
  logic [33:0]              muu, mvv, auv, mr0, mr1;
  logic                     suv, sr0, sr1;

  always_comb begin
    muu_s = g_r[0] + EPS_Q10;
    mvv_s = g_r[1] + EPS_Q10;
    muu   = muu_s[33:0];
    mvv   = mvv_s[33:0];
    nuv   = -g_r[2];
    nr0   = -g_r[3];
    nr1   = -g_r[4];
    suv   = g_r[2][GRAM_W-1];
    sr0   = g_r[3][GRAM_W-1];
    sr1   = g_r[4][GRAM_W-1];
    auv   = suv ? nuv[33:0] : g_r[2][33:0];
    mr0   = sr0 ? nr0[33:0] : g_r[3][33:0];
    mr1   = sr1 ? nr1[33:0] : g_r[4][33:0];
  end

  // shared multiplier and operand select
  logic [1:0]               pidx;
  logic [1:0]               cidx;
  logic signed [MUL_W-1:0]  mul_x, mul_y, dd;
  logic signed [2*MUL_W-1:0] mul_p;

  assign cidx = cnt_r[1:0];
  assign pidx = (cnt_r >= 5'd3) ? 2'(cnt_r - 5'd3) : cnt_r[1:0];
  assign dd   = MUL_W'(pa_r[cidx]) - MUL_W'(pb_r[cidx]);

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state_r)
      S_DOT: begin
        case (dp_r)
          3'd0: begin mul_x = MUL_W'(u_r[cidx]); mul_y = MUL_W'(u_r[cidx]); end
          3'd1: begin mul_x = MUL_W'(v_r[cidx]); mul_y = MUL_W'(v_r[cidx]); end
          3'd2: begin mul_x = MUL_W'(u_r[cidx]); mul_y = MUL_W'(v_r[cidx]); end
          3'd3: begin mul_x = MUL_W'(u_r[cidx]); mul_y = MUL_W'(h_r[cidx]); end
          3'd4: begin mul_x = MUL_W'(v_r[cidx]); mul_y = MUL_W'(h_r[cidx]); end
          default: begin mul_x = '0; mul_y = '0; end
        endcase
      end
      S_MAT: begin
        case (cnt_r)
          5'd0: begin mul_x = {1'b0, muu}; mul_y = {1'b0, mvv}; end
          5'd1: begin mul_x = {1'b0, auv}; mul_y = {1'b0, auv}; end
          5'd2: begin mul_x = {1'b0, mr0}; mul_y = {1'b0, mvv}; end
          5'd3: begin mul_x = {1'b0, auv}; mul_y = {1'b0, mr1}; end
          5'd4: begin mul_x = {1'b0, mr1}; mul_y = {1'b0, muu}; end
          5'd5: begin mul_x = {1'b0, auv}; mul_y = {1'b0, mr0}; end
          default: begin mul_x = '0; mul_y = '0; end
        endcase
      end
      S_PNT: begin
        if (cnt_r < 5'd3) begin
          mul_x = MUL_W'(u_r[pidx]);
          mul_y = MUL_W'({1'b0, alpha_r});
        end else begin
          mul_x = MUL_W'(w_r[pidx]);
          mul_y = MUL_W'({1'b0, beta_r});
        end
      end
      S_DSQ: begin
        mul_x = dd;
        mul_y = dd;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  // accumulate and round
  logic signed [ACC_W-1:0] acc_sum, acc_rnd;
  logic [63:0]             det_c;

  assign acc_sum = acc_r + mul_p[ACC_W-1:0];
  assign acc_rnd = acc_sum + ACC_W'(512);
  assign det_c   = (prod_r > mul_p[63:0]) ? (prod_r - mul_p[63:0]) : 64'd1;

  // coefficient clamp ahead of the divider
  logic        pneg, qneg, early;
  logic [63:0] pm, qm;
  logic [64:0] nsum, num;
  logic [COEF_FRAC:0] early_val;

  always_comb begin
    pneg      = sel_r ? sr1 : sr0;
    qneg      = sel_r ? (suv ^ sr0) : (suv ^ sr1);
    pm        = sel_r ? pmb_r : pma_r;
    qm        = sel_r ? qmb_r : qma_r;
    nsum      = {1'b0, pm} + {1'b0, qm};
    num       = '0;
    early     = 1'b0;
    early_val = '0;
    if (pneg && !qneg) begin
      early = 1'b1;
    end else if (!pneg && qneg) begin
      num = nsum;
      if (nsum[64]) begin
        early     = 1'b1;
        early_val = COEF_ONE;
      end
    end else if (!pneg) begin
      if (pm <= qm) early = 1'b1;
      num = {1'b0, pm - qm};
    end else begin
      if (qm <= pm) early = 1'b1;
      num = {1'b0, qm - pm};
    end
    if (!early && num >= {1'b0, det_r}) begin
      early     = 1'b1;
      early_val = COEF_ONE;
    end
  end

  // restoring divider step
  logic [64:0]          rem2;
  logic                 div_ge;
  logic [63:0]          rem_next;
  logic [COEF_FRAC-1:0] q_next;

  assign rem2     = {rem_r, 1'b0};
  assign div_ge   = rem2 >= {1'b0, det_r};
  assign rem_next = div_ge ? 64'(rem2 - {1'b0, det_r}) : rem2[63:0];
  assign q_next   = {q_r[COEF_FRAC-2:0], div_ge};

  // projected point coordinate
  logic signed [2*MUL_W-1:0] prnd;
  logic signed [21:0]        poff, psum;

  assign prnd = mul_p + (2*MUL_W)'(32768);
  assign poff = prnd[COEF_FRAC+21:COEF_FRAC];
  assign psum = ((cnt_r < 5'd3) ? 22'(a0_r[pidx]) : 22'(b0_r[pidx])) + poff;

  // square root step
  logic [ACC_W-1:0] sq_tmp;
  logic             sq_ge;

  assign sq_tmp = sq_res_r + sq_bit_r;
  assign sq_ge  = sq_x_r >= sq_tmp;

  // running minimum
  logic [DIST_W-1:0] cmp_base, upd_dist;
  logic [59:0]       upd_a, upd_b;
  logic              take;

  always_comb begin
    cmp_base = first_r ? DIST_INIT : best_dist_r;
    take     = sq_res_r[DIST_W-1:0] < cmp_base;
    upd_dist = take ? sq_res_r[DIST_W-1:0] : cmp_base;
    upd_a    = take ? {pa_r[2], pa_r[1], pa_r[0]} : best_a_r;
    upd_b    = take ? {pb_r[2], pb_r[1], pb_r[0]} : best_b_r;
  end

  // output register control
  logic out_load, out_valid_nxt;

  always_comb begin
    out_load = (state_r == S_UPD) && last_r && (!out_valid_r || out_ready);
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      dp_r        <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
      best_dist_r <= DIST_INIT;
      best_a_r    <= '0;
      best_b_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < 3; i++) begin
              a0_r[i] <= ld_a0[i];
              b0_r[i] <= ld_b0[i];
              u_r[i]  <= DIFF_W'(ld_a1[i]) - DIFF_W'(ld_a0[i]);
              v_r[i]  <= DIFF_W'(ld_b0[i]) - DIFF_W'(ld_b1[i]);
              h_r[i]  <= DIFF_W'(ld_b0[i]) - DIFF_W'(ld_a0[i]);
              w_r[i]  <= DIFF_W'(ld_b1[i]) - DIFF_W'(ld_b0[i]);
            end
            first_r <= in_data.first_pair;
            last_r  <= in_data.last_pair;
            acc_r   <= '0;
            cnt_r   <= '0;
            dp_r    <= '0;
            state_r <= S_DOT;
          end
        end
        S_DOT: begin
          if (cnt_r == 5'd2) begin
            g_r[dp_r] <= acc_rnd[ACC_W-1:10];
            acc_r     <= '0;
            cnt_r     <= '0;
            if (dp_r == 3'd4) begin
              state_r <= S_MAT;
            end else begin
              dp_r <= dp_r + 3'd1;
            end
          end else begin
            acc_r <= acc_sum;
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_MAT: begin
          cnt_r <= cnt_r + 5'd1;
          case (cnt_r)
            5'd0: prod_r <= mul_p[63:0];
            5'd1: det_r  <= det_c;
            5'd2: pma_r  <= mul_p[63:0];
            5'd3: qma_r  <= mul_p[63:0];
            5'd4: pmb_r  <= mul_p[63:0];
            default: begin
              qmb_r   <= mul_p[63:0];
              cnt_r   <= '0;
              sel_r   <= 1'b0;
              state_r <= S_COEF;
            end
          endcase
        end
        S_COEF: begin
          if (early) begin
            if (sel_r) begin
              beta_r  <= early_val;
              cnt_r   <= '0;
              state_r <= S_PNT;
            end else begin
              alpha_r <= early_val;
              sel_r   <= 1'b1;
            end
          end else begin
            rem_r   <= num[63:0];
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_next;
          q_r   <= q_next;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(COEF_FRAC - 1)) begin
            cnt_r <= '0;
            if (sel_r) begin
              beta_r  <= {1'b0, q_next};
              state_r <= S_PNT;
            end else begin
              alpha_r <= {1'b0, q_next};
              sel_r   <= 1'b1;
              state_r <= S_COEF;
            end
          end
        end
        S_PNT: begin
          if (cnt_r < 5'd3) begin
            pa_r[pidx] <= psum[COORD_W-1:0];
          end else begin
            pb_r[pidx] <= psum[COORD_W-1:0];
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd5) begin
            cnt_r   <= '0;
            acc_r   <= '0;
            state_r <= S_DSQ;
          end
        end
        S_DSQ: begin
          acc_r <= acc_sum;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd2) begin
            sq_x_r   <= acc_sum;
            sq_res_r <= '0;
            sq_bit_r <= SQRT_BIT0;
            cnt_r    <= '0;
            state_r  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_x_r   <= sq_x_r - sq_tmp;
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          cnt_r    <= cnt_r + 5'd1;
          if (cnt_r == 5'd22) begin
            cnt_r   <= '0;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (!last_r || !out_valid_r || out_ready) begin
            best_dist_r <= upd_dist;
            best_a_r    <= upd_a;
            best_b_r    <= upd_b;
            if (last_r) begin
              out_r.min_distance <= upd_dist;
              out_r.closest_on_a <= upd_a;
              out_r.closest_on_b <= upd_b;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
